// ===== rtl/csvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and character codes for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_FEND = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [7:0]  col;
    logic [15:0] row;
    logic        le;
  } res_t;

  // Up to three results caused by one byte, packed to the low slots.
  typedef struct packed {
    logic           be;
    logic [1:0]     cnt;
    res_t [2:0]     slot;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ===== rtl/csvt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_front
// Accepts bytes, tracks quoting and line state, and builds result bundles.
// ----------------------------------------------------------------------------
module csvt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_is_last,
  input  csvt_pkg::qstat_t  qstat,
  output logic              push,
  output csvt_pkg::bundle_t push_data
);
  import csvt_pkg::*;

  logic        iq_r, iq_nxt;
  logic        qp_r, qp_nxt;
  logic        crp_r, crp_nxt;
  logic        fn_r, fn_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic        acc;
  logic        term, done;
  logic        v0, v1, v2;
  res_t        s0, s1, s2;
  logic [7:0]  b_map;

  assign in_ready = !qstat.full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    iq_nxt  = iq_r;
    qp_nxt  = qp_r;
    crp_nxt = crp_r;
    fn_nxt  = fn_r;
    col_nxt = col_r;
    row_nxt = row_r;
    term = 1'b0;
    done = 1'b0;
    v0 = 1'b0;
    v1 = 1'b0;
    v2 = 1'b0;
    s0 = '0;
    s1 = '0;
    s2 = '0;
    b_map = in_data_byte;
    if ((in_data_byte != CH_TAB) && (in_data_byte < CH_SPACE)) begin
      b_map = CH_TILDE;
    end

    // First the decision left open by the previous byte.
    if (qp_r) begin
      qp_nxt = 1'b0;
      if (in_data_byte == CH_QUOTE) begin
        v0 = 1'b1;
        s0 = '{kind: KIND_CHAR, ch: CH_QUOTE, col: col_nxt, row: row_nxt, le: 1'b0};
        fn_nxt = 1'b1;
        done = 1'b1;
      end else begin
        iq_nxt = 1'b0;
      end
    end else if (crp_r) begin
      crp_nxt = 1'b0;
      if (in_data_byte != CH_LF) begin
        if (!(col_nxt == '0 && !fn_nxt)) begin
          v0 = 1'b1;
          s0 = '{kind: KIND_FEND, ch: 8'h00, col: col_nxt, row: row_nxt, le: 1'b1};
          if (row_nxt != 16'hFFFF) row_nxt = row_nxt + 16'd1;
          col_nxt = '0;
        end
        fn_nxt = 1'b0;
        iq_nxt = 1'b0;
      end
    end

    // Then the byte itself.
    if (!done) begin
      if (iq_nxt) begin
        if (in_data_byte == CH_QUOTE) begin
          if (in_is_last) iq_nxt = 1'b0;
          else qp_nxt = 1'b1;
        end else begin
          v1 = 1'b1;
          s1 = '{kind: KIND_CHAR, ch: in_data_byte, col: col_nxt, row: row_nxt, le: 1'b0};
          fn_nxt = 1'b1;
        end
      end else if (in_data_byte == CH_QUOTE) begin
        iq_nxt = 1'b1;
      end else if (in_data_byte == CH_COMMA) begin
        term = 1'b1;
        v1 = 1'b1;
        s1 = '{kind: KIND_FEND, ch: 8'h00, col: col_nxt, row: row_nxt, le: 1'b0};
        if (col_nxt != 8'hFF) col_nxt = col_nxt + 8'd1;
        fn_nxt = 1'b0;
        iq_nxt = 1'b0;
      end else if ((in_data_byte == CH_LF) || (in_data_byte == CH_CR && in_is_last)) begin
        term = 1'b1;
        if (!(col_nxt == '0 && !fn_nxt)) begin
          v1 = 1'b1;
          s1 = '{kind: KIND_FEND, ch: 8'h00, col: col_nxt, row: row_nxt, le: 1'b1};
          if (row_nxt != 16'hFFFF) row_nxt = row_nxt + 16'd1;
          col_nxt = '0;
        end
        fn_nxt = 1'b0;
        iq_nxt = 1'b0;
      end else if (in_data_byte == CH_CR) begin
        crp_nxt = 1'b1;
      end else begin
        v1 = 1'b1;
        s1 = '{kind: KIND_CHAR, ch: b_map, col: col_nxt, row: row_nxt, le: 1'b0};
        fn_nxt = 1'b1;
      end
    end

    // The final byte closes any open field and returns to the reset state.
    if (in_is_last) begin
      if (!term && !(col_nxt == '0 && !fn_nxt)) begin
        v2 = 1'b1;
        s2 = '{kind: KIND_FEND, ch: 8'h00, col: col_nxt, row: row_nxt, le: 1'b0};
      end
      iq_nxt  = 1'b0;
      qp_nxt  = 1'b0;
      crp_nxt = 1'b0;
      fn_nxt  = 1'b0;
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  // Pack the valid slots toward slot 0 so the back end walks them in order.
  always_comb begin
    push_data.be   = in_is_last;
    push_data.cnt  = 2'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});
    push_data.slot = '0;
    if (v0) begin
      push_data.slot[0] = s0;
      if (v1) begin
        push_data.slot[1] = s1;
        push_data.slot[2] = s2;
      end else begin
        push_data.slot[1] = s2;
      end
    end else if (v1) begin
      push_data.slot[0] = s1;
      push_data.slot[1] = s2;
    end else begin
      push_data.slot[0] = s2;
    end
  end

  assign push = acc && (v0 || v1 || v2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r  <= 1'b0;
      qp_r  <= 1'b0;
      crp_r <= 1'b0;
      fn_r  <= 1'b0;
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      iq_r  <= iq_nxt;
      qp_r  <= qp_nxt;
      crp_r <= crp_nxt;
      fn_r  <= fn_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== rtl/csvt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_queue
// Short register queue of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
module csvt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csvt_pkg::bundle_t push_data,
  input  logic              pop,
  output csvt_pkg::bundle_t head,
  output csvt_pkg::qstat_t  qstat
);
  import csvt_pkg::*;

  bundle_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (QAW+1)'(1);
    else if (!do_push && do_pop) count_nxt = count_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/csvt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_back
// Walks the results of the head bundle and presents them one per transfer.
// ----------------------------------------------------------------------------
module csvt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  csvt_pkg::bundle_t head,
  input  csvt_pkg::qstat_t  qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_char_out,
  output logic [7:0]        out_column_index,
  output logic [15:0]       out_row_index,
  output logic              out_line_end,
  output logic              out_buffer_end
);
  import csvt_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       at_tail;
  res_t       cur;

  assign cur       = head.slot[idx_r];
  assign at_tail   = (idx_r == head.cnt - 2'd1);
  assign out_valid = !qstat.empty;
  assign pop       = out_valid && out_ready && at_tail;

  assign out_kind         = cur.kind;
  assign out_char_out     = cur.ch;
  assign out_column_index = cur.col;
  assign out_row_index    = cur.row;
  assign out_line_end     = cur.le;
  assign out_buffer_end   = head.be && at_tail;

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = at_tail ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps
// A result is registered in the bundle queue before it is offered.
// Throughput: one byte per cycle while the output is ready and each byte yields
// at most one result; a byte that yields k results holds the output for k
// transfers, and a four-entry bundle queue absorbs the difference.
// Reset: synchronous, active low; clears parser state and empties the queue.
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV splitter: one byte in, value characters and field ends out.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_char_out,
  output logic [7:0]  out_column_index,
  output logic [15:0] out_row_index,
  output logic        out_line_end,
  output logic        out_buffer_end
);
  import csvt_pkg::*;

  logic    push, pop;
  bundle_t push_data, head;
  qstat_t  qstat;

  csvt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  csvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  csvt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .qstat            (qstat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_char_out     (out_char_out),
    .out_column_index (out_column_index),
    .out_row_index    (out_row_index),
    .out_line_end     (out_line_end),
    .out_buffer_end   (out_buffer_end)
  );

endmodule

// ===== rtl/csvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_assertions
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module csvt_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_char_out,
  input logic [7:0]  out_column_index,
  input logic [15:0] out_row_index,
  input logic        out_line_end,
  input logic        out_buffer_end
);
  import csvt_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out)
      && $stable(out_kind) && $stable(out_row_index) && $stable(out_column_index)
      && $stable(out_line_end) && $stable(out_buffer_end))
    else $error("result changed while stalled");

  // Value characters never close a line.
  a_char_no_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CHAR |-> !out_line_end)
    else $error("value character flagged as line end");

  // Field ends carry no character.
  a_fend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FEND |-> out_char_out == 8'h00)
    else $error("field end with nonzero character");

endmodule

bind csv_field_tokenizer csvt_assertions u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_char_out     (out_char_out),
  .out_column_index (out_column_index),
  .out_row_index    (out_row_index),
  .out_line_end     (out_line_end),
  .out_buffer_end   (out_buffer_end)
);
